>>> src/sts_pkg.sv
// Shared types, character codes, token kinds and helpers for the source token scanner.
package sts_pkg;

  localparam int OFFSET_WIDTH_D = 24;
  localparam int LENGTH_WIDTH_D = 16;
  localparam int LINE_WIDTH_D   = 16;

  localparam int KIND_W = 5;
  localparam int QDEPTH = 3;

  typedef enum logic [10:0] {
    M_IDLE      = 11'b000_0000_0001,
    M_IDENT     = 11'b000_0000_0010,
    M_NUM       = 11'b000_0000_0100,
    M_NUMDOT    = 11'b000_0000_1000,
    M_FRAC      = 11'b000_0001_0000,
    M_STRING    = 11'b000_0010_0000,
    M_OP2       = 11'b000_0100_0000,
    M_SLASH     = 11'b000_1000_0000,
    M_LINECOM   = 11'b001_0000_0000,
    M_BLOCK     = 11'b010_0000_0000,
    M_BLOCKSTAR = 11'b100_0000_0000
  } sts_mode_t;

  typedef struct packed {
    logic idle;
    logic pos_zero;
    logic line_one;
  } sts_stat_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_Z   = 8'h5A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_Z   = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  localparam logic [KIND_W-1:0] K_LPAREN = 5'd0;
  localparam logic [KIND_W-1:0] K_RPAREN = 5'd1;
  localparam logic [KIND_W-1:0] K_LBRACE = 5'd2;
  localparam logic [KIND_W-1:0] K_RBRACE = 5'd3;
  localparam logic [KIND_W-1:0] K_COMMA  = 5'd4;
  localparam logic [KIND_W-1:0] K_DOT    = 5'd5;
  localparam logic [KIND_W-1:0] K_MINUS  = 5'd6;
  localparam logic [KIND_W-1:0] K_PLUS   = 5'd7;
  localparam logic [KIND_W-1:0] K_SEMI   = 5'd8;
  localparam logic [KIND_W-1:0] K_SLASH  = 5'd9;
  localparam logic [KIND_W-1:0] K_STAR   = 5'd10;
  localparam logic [KIND_W-1:0] K_BANG   = 5'd11;
  localparam logic [KIND_W-1:0] K_NE     = 5'd12;
  localparam logic [KIND_W-1:0] K_ASSIGN = 5'd13;
  localparam logic [KIND_W-1:0] K_EQEQ   = 5'd14;
  localparam logic [KIND_W-1:0] K_GT     = 5'd15;
  localparam logic [KIND_W-1:0] K_GE     = 5'd16;
  localparam logic [KIND_W-1:0] K_LT     = 5'd17;
  localparam logic [KIND_W-1:0] K_LE     = 5'd18;
  localparam logic [KIND_W-1:0] K_IDENT  = 5'd19;
  localparam logic [KIND_W-1:0] K_NUMBER = 5'd20;
  localparam logic [KIND_W-1:0] K_STRING = 5'd21;
  localparam logic [KIND_W-1:0] K_EOF    = 5'd22;
  localparam logic [KIND_W-1:0] K_BAD    = 5'd23;
  localparam logic [KIND_W-1:0] K_UNTERM = 5'd24;

  localparam logic [1:0] P_BANG = 2'd0;
  localparam logic [1:0] P_EQ   = 2'd1;
  localparam logic [1:0] P_LT   = 2'd2;
  localparam logic [1:0] P_GT   = 2'd3;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z) ||
           (c == CH_UNDER);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO && c <= CH_NINE);
  endfunction

  function automatic logic [KIND_W-1:0] op_single(input logic [1:0] p);
    logic [KIND_W-1:0] k;
    case (p)
      P_BANG:  k = K_BANG;
      P_EQ:    k = K_ASSIGN;
      P_LT:    k = K_LT;
      P_GT:    k = K_GT;
      default: k = K_BANG;
    endcase
    return k;
  endfunction

  function automatic logic [KIND_W-1:0] op_double(input logic [1:0] p);
    logic [KIND_W-1:0] k;
    case (p)
      P_BANG:  k = K_NE;
      P_EQ:    k = K_EQEQ;
      P_LT:    k = K_LE;
      P_GT:    k = K_GE;
      default: k = K_NE;
    endcase
    return k;
  endfunction

endpackage

>>> src/sts_core.sv
// Scan state registers and the per-byte token logic producing up to three tokens.
module sts_core #(
  parameter int OFFSET_WIDTH = sts_pkg::OFFSET_WIDTH_D,
  parameter int LENGTH_WIDTH = sts_pkg::LENGTH_WIDTH_D,
  parameter int LINE_WIDTH   = sts_pkg::LINE_WIDTH_D,
  localparam int ENT_W = sts_pkg::KIND_W + OFFSET_WIDTH + LENGTH_WIDTH + LINE_WIDTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          ch,
  output logic [1:0]          new_cnt,
  output logic [ENT_W-1:0]    new_ent [sts_pkg::QDEPTH],
  output sts_pkg::sts_stat_t  stat
);
  import sts_pkg::*;

  sts_mode_t                 mode_r, mode_nxt;
  logic [OFFSET_WIDTH-1:0]   pos_r, pos_nxt;
  logic [OFFSET_WIDTH-1:0]   ts_r, ts_nxt;
  logic [LINE_WIDTH-1:0]     line_r, line_nxt;
  logic [1:0]                pend_r, pend_nxt;
  logic [LENGTH_WIDTH-1:0]   lc_r, lc_nxt;

  logic [LENGTH_WIDTH-1:0]   lc_inc, lc_inc2;
  logic [LENGTH_WIDTH:0]     lc_sum2;
  logic [LINE_WIDTH-1:0]     line_inc;
  logic [OFFSET_WIDTH-1:0]   pos_dec;

  logic [KIND_W-1:0]         e_kind  [QDEPTH];
  logic [OFFSET_WIDTH-1:0]   e_start [QDEPTH];
  logic [LENGTH_WIDTH-1:0]   e_len   [QDEPTH];
  logic [1:0]                n;
  logic                      retry;
  logic                      eof;

  assign lc_inc   = (lc_r == '1) ? lc_r : lc_r + LENGTH_WIDTH'(1);
  assign lc_sum2  = {1'b0, lc_r} + (LENGTH_WIDTH + 1)'(2);
  assign lc_inc2  = lc_sum2[LENGTH_WIDTH] ? '1 : lc_sum2[LENGTH_WIDTH-1:0];
  assign line_inc = (line_r == '1) ? line_r : line_r + LINE_WIDTH'(1);
  assign pos_dec  = pos_r - OFFSET_WIDTH'(1);

  always_comb begin
    mode_nxt = mode_r;
    pos_nxt  = pos_r;
    ts_nxt   = ts_r;
    line_nxt = line_r;
    pend_nxt = pend_r;
    lc_nxt   = lc_r;
    n        = 2'd0;
    retry    = 1'b0;
    eof      = 1'b0;
    for (int i = 0; i < QDEPTH; i++) begin
      e_kind[i]  = '0;
      e_start[i] = '0;
      e_len[i]   = '0;
    end

    case (mode_r)
      M_IDENT: begin
        if (is_alpha(ch) || is_digit(ch)) begin
          lc_nxt = lc_inc;
        end else begin
          e_kind[n] = K_IDENT; e_start[n] = ts_r; e_len[n] = lc_r; n = n + 2'd1;
          retry = 1'b1;
        end
      end
      M_NUM: begin
        if (is_digit(ch)) begin
          lc_nxt = lc_inc;
        end else if (ch == CH_DOT) begin
          mode_nxt = M_NUMDOT;
        end else begin
          e_kind[n] = K_NUMBER; e_start[n] = ts_r; e_len[n] = lc_r; n = n + 2'd1;
          retry = 1'b1;
        end
      end
      M_NUMDOT: begin
        if (is_digit(ch)) begin
          lc_nxt   = lc_inc2;
          mode_nxt = M_FRAC;
        end else begin
          e_kind[n] = K_NUMBER; e_start[n] = ts_r; e_len[n] = lc_r; n = n + 2'd1;
          e_kind[n] = K_DOT; e_start[n] = pos_dec; e_len[n] = LENGTH_WIDTH'(1);
          n = n + 2'd1;
          retry = 1'b1;
        end
      end
      M_FRAC: begin
        if (is_digit(ch)) begin
          lc_nxt = lc_inc;
        end else begin
          e_kind[n] = K_NUMBER; e_start[n] = ts_r; e_len[n] = lc_r; n = n + 2'd1;
          retry = 1'b1;
        end
      end
      M_STRING: begin
        if (ch == CH_NUL) begin
          e_kind[n] = K_UNTERM; e_start[n] = ts_r; e_len[n] = lc_r; n = n + 2'd1;
          retry = 1'b1;
        end else begin
          lc_nxt = lc_inc;
          if (ch == CH_QUOTE) begin
            e_kind[n] = K_STRING; e_start[n] = ts_r; e_len[n] = lc_inc; n = n + 2'd1;
            mode_nxt = M_IDLE;
          end else if (ch == CH_LF) begin
            line_nxt = line_inc;
          end
        end
      end
      M_OP2: begin
        if (ch == CH_EQ) begin
          e_kind[n] = op_double(pend_r); e_start[n] = ts_r;
          e_len[n] = LENGTH_WIDTH'(2); n = n + 2'd1;
          mode_nxt = M_IDLE;
        end else begin
          e_kind[n] = op_single(pend_r); e_start[n] = ts_r;
          e_len[n] = LENGTH_WIDTH'(1); n = n + 2'd1;
          retry = 1'b1;
        end
      end
      M_SLASH: begin
        if (ch == CH_SLASH) begin
          mode_nxt = M_LINECOM;
        end else if (ch == CH_STAR) begin
          mode_nxt = M_BLOCK;
        end else begin
          e_kind[n] = K_SLASH; e_start[n] = ts_r; e_len[n] = LENGTH_WIDTH'(1);
          n = n + 2'd1;
          retry = 1'b1;
        end
      end
      M_LINECOM: begin
        if (ch == CH_LF) begin
          line_nxt = line_inc;
          mode_nxt = M_IDLE;
        end else begin
          retry = (ch == CH_NUL);
        end
      end
      M_BLOCK, M_BLOCKSTAR: begin
        if (ch == CH_NUL) begin
          retry = 1'b1;
        end else if (mode_r == M_BLOCKSTAR && ch == CH_SLASH) begin
          mode_nxt = M_IDLE;
        end else if (ch == CH_STAR) begin
          mode_nxt = M_BLOCKSTAR;
        end else begin
          if (ch == CH_LF) begin
            line_nxt = line_inc;
          end
          mode_nxt = M_BLOCK;
        end
      end
      default: begin
        retry = 1'b1;
      end
    endcase

    if (retry) begin
      mode_nxt = M_IDLE;
      if (is_alpha(ch)) begin
        mode_nxt = M_IDENT; ts_nxt = pos_r; lc_nxt = LENGTH_WIDTH'(1);
      end else if (is_digit(ch)) begin
        mode_nxt = M_NUM; ts_nxt = pos_r; lc_nxt = LENGTH_WIDTH'(1);
      end else begin
        case (ch)
          CH_NUL: begin
            e_kind[n] = K_EOF; e_start[n] = pos_r; e_len[n] = '0; n = n + 2'd1;
            eof = 1'b1;
          end
          CH_SPACE, CH_CR, CH_TAB: begin
          end
          CH_LF: line_nxt = line_inc;
          CH_SLASH: begin
            mode_nxt = M_SLASH; ts_nxt = pos_r; lc_nxt = LENGTH_WIDTH'(1);
          end
          CH_QUOTE: begin
            mode_nxt = M_STRING; ts_nxt = pos_r; lc_nxt = LENGTH_WIDTH'(1);
          end
          CH_BANG, CH_EQ, CH_LT, CH_GT: begin
            mode_nxt = M_OP2; ts_nxt = pos_r; lc_nxt = LENGTH_WIDTH'(1);
            pend_nxt = (ch == CH_BANG) ? P_BANG :
                       (ch == CH_EQ)   ? P_EQ   :
                       (ch == CH_LT)   ? P_LT   : P_GT;
          end
          default: begin
            e_start[n] = pos_r;
            e_len[n]   = LENGTH_WIDTH'(1);
            case (ch)
              CH_LPAREN: e_kind[n] = K_LPAREN;
              CH_RPAREN: e_kind[n] = K_RPAREN;
              CH_LBRACE: e_kind[n] = K_LBRACE;
              CH_RBRACE: e_kind[n] = K_RBRACE;
              CH_COMMA:  e_kind[n] = K_COMMA;
              CH_DOT:    e_kind[n] = K_DOT;
              CH_MINUS:  e_kind[n] = K_MINUS;
              CH_PLUS:   e_kind[n] = K_PLUS;
              CH_SEMI:   e_kind[n] = K_SEMI;
              CH_STAR:   e_kind[n] = K_STAR;
              default:   e_kind[n] = K_BAD;
            endcase
            n = n + 2'd1;
          end
        endcase
      end
    end

    if (eof) begin
      mode_nxt = M_IDLE;
      pos_nxt  = '0;
      ts_nxt   = '0;
      line_nxt = LINE_WIDTH'(1);
      pend_nxt = P_BANG;
      lc_nxt   = '0;
    end else begin
      pos_nxt = pos_r + OFFSET_WIDTH'(1);
    end
  end

  assign new_cnt = n;

  always_comb begin
    for (int i = 0; i < QDEPTH; i++) begin
      new_ent[i] = {line_r, e_len[i], e_start[i], e_kind[i]};
    end
  end

  assign stat.idle     = (mode_r == M_IDLE);
  assign stat.pos_zero = (pos_r == '0);
  assign stat.line_one = (line_r == LINE_WIDTH'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      pos_r  <= '0;
      ts_r   <= '0;
      line_r <= LINE_WIDTH'(1);
      pend_r <= P_BANG;
      lc_r   <= '0;
    end else if (step) begin
      mode_r <= mode_nxt;
      pos_r  <= pos_nxt;
      ts_r   <= ts_nxt;
      line_r <= line_nxt;
      pend_r <= pend_nxt;
      lc_r   <= lc_nxt;
    end
  end

endmodule

>>> src/sts_outq.sv
// Three-entry result queue: loads a byte's tokens in order and drains one per transfer.
module sts_outq #(
  parameter int ENT_W = 61
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic [1:0]        new_cnt,
  input  logic [ENT_W-1:0]  new_ent [sts_pkg::QDEPTH],
  input  logic              pop,
  output logic [1:0]        room,
  output logic              head_vld,
  output logic [ENT_W-1:0]  head_ent,
  output logic              head_last
);
  import sts_pkg::*;

  logic [ENT_W-1:0] ent_r  [QDEPTH];
  logic [ENT_W-1:0] ent_nxt[QDEPTH];
  logic             last_r [QDEPTH];
  logic             last_nxt[QDEPTH];
  logic [1:0]       cnt_r, cnt_nxt;
  logic [1:0]       keep;
  logic [1:0]       add;
  logic [1:0]       src;
  logic [1:0]       k;

  assign keep = cnt_r - {1'b0, pop};
  assign add  = load ? new_cnt : 2'd0;
  assign room = 2'(QDEPTH) - keep;

  always_comb begin
    for (int j = 0; j < QDEPTH; j++) begin
      src         = 2'(j) + {1'b0, pop};
      k           = 2'(j) - keep;
      ent_nxt[j]  = ent_r[j];
      last_nxt[j] = last_r[j];
      if (2'(j) < keep) begin
        ent_nxt[j]  = ent_r[src];
        last_nxt[j] = last_r[src];
      end else if (k < add) begin
        ent_nxt[j]  = new_ent[k];
        last_nxt[j] = (k == add - 2'd1);
      end
    end
    cnt_nxt = keep + add;
  end

  assign head_vld  = (cnt_r != 2'd0);
  assign head_ent  = ent_r[0];
  assign head_last = last_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < QDEPTH; j++) begin
      ent_r[j]  <= ent_nxt[j];
      last_r[j] <= last_nxt[j];
    end
  end

endmodule

>>> src/source_token_scanner.sv
// Source token scanner top level: input register, scan core and result queue.
//
// Takes one source byte per transfer and returns tokens (kind, start offset,
// length, line) with tlast on the final token a byte produces. A byte enters
// the input register, is scanned by the core from there and its tokens
// (zero to three) land in a three-entry result queue; the first token is valid
// on the output once the queue registers have loaded it. With the output side
// ready, one byte is taken every cycle as long as each byte yields at most one
// token. The queue sends one token per cycle while the output side is ready, so
// tokens beyond one per byte build a backlog there; a byte whose tokens do not
// fit in the free entries is held in the input register until enough entries
// are free. Byte zero ends the source: it flushes any open token, gives an EOF
// token and returns all counters to their reset values. No clearing pass
// follows reset.
module source_token_scanner #(
  parameter int OFFSET_WIDTH = sts_pkg::OFFSET_WIDTH_D,
  parameter int LENGTH_WIDTH = sts_pkg::LENGTH_WIDTH_D,
  parameter int LINE_WIDTH   = sts_pkg::LINE_WIDTH_D,
  localparam int ENT_W  = sts_pkg::KIND_W + OFFSET_WIDTH + LENGTH_WIDTH + LINE_WIDTH,
  localparam int DATA_W = ((ENT_W + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // ch
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,  // kind, start_offset, token_length, line_number
  output logic              out_tlast
);
  import sts_pkg::*;

  logic              in_vld_r;
  logic [7:0]        ch_r;
  logic              consume;
  logic              pop;
  logic [1:0]        room;
  logic [1:0]        new_cnt;
  logic [ENT_W-1:0]  new_ent [QDEPTH];
  logic [ENT_W-1:0]  head_ent;
  sts_stat_t         stat;

  assign consume   = in_vld_r && (new_cnt <= room);
  assign in_tready = !in_vld_r || consume;
  assign pop       = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      ch_r <= in_tdata;
    end
  end

  sts_core #(
    .OFFSET_WIDTH (OFFSET_WIDTH),
    .LENGTH_WIDTH (LENGTH_WIDTH),
    .LINE_WIDTH   (LINE_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (consume),
    .ch      (ch_r),
    .new_cnt (new_cnt),
    .new_ent (new_ent),
    .stat    (stat)
  );

  sts_outq #(
    .ENT_W (ENT_W)
  ) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (consume),
    .new_cnt   (new_cnt),
    .new_ent   (new_ent),
    .pop       (pop),
    .room      (room),
    .head_vld  (out_tvalid),
    .head_ent  (head_ent),
    .head_last (out_tlast)
  );

  assign out_tdata = DATA_W'(head_ent);

  a_eof_emits: assert property (@(posedge clk) disable iff (!rst_n)
    consume && ch_r == CH_NUL |-> new_cnt != 2'd0)
    else $error("end of source produced no token");

  a_eof_resets: assert property (@(posedge clk) disable iff (!rst_n)
    consume && ch_r == CH_NUL |=> stat.idle && stat.pos_zero && stat.line_one)
    else $error("scan state not reset after end of source");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[KIND_W-1:0] <= K_UNTERM)
    else $error("token kind out of range");

endmodule
